/* hw/rtl/swdk_pkg.sv */
// swdk_pkg: shared types, constants and the seven-segment decode for the
// stopwatch with debounced keys. No dependencies.
`timescale 1ns / 1ps

package swdk_pkg;

   localparam int DIGIT_COUNT      = 6;
   localparam int DEBOUNCE_SAMPLES = 8;
   localparam int SECONDS_WRAP     = 10000;
   // decimal digits held for the seconds count (enough for SECONDS_WRAP - 1)
   localparam int SEC_BCD_DIGITS   = 4;
   localparam int HUND_LAST        = 99;

   localparam logic [7:0] SEG_BLANK = 8'hFF;
   localparam logic [7:0] SEG_DP    = 8'h7F;
   localparam logic [7:0] TPH_RESET = 8'd5;

   typedef struct packed {
      logic stop_key_level;
      logic start_key_level;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  digit_select;
      logic [7:0]  segment_pattern;
      logic        is_running;
      logic [6:0]  hundredths_now;
      logic [13:0] seconds_now;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0][3:0]                hund_bcd;
      logic [SEC_BCD_DIGITS-1:0][3:0] sec_bcd;
   } count_view_type;

   typedef struct packed {
      logic        running;
      logic [6:0]  hundredths;
      logic [13:0] seconds;
   } count_state_type;

   function automatic logic [7:0] seg_decode(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0: seg = 8'hC0;
         4'd1: seg = 8'hF9;
         4'd2: seg = 8'hA4;
         4'd3: seg = 8'hB0;
         4'd4: seg = 8'h99;
         4'd5: seg = 8'h92;
         4'd6: seg = 8'h82;
         4'd7: seg = 8'hF8;
         4'd8: seg = 8'h80;
         4'd9: seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

/* hw/rtl/swdk_debounce.sv */
// swdk_debounce: sample history and debounced level for one key; flags a
// debounced release. Depends on swdk_pkg.
`timescale 1ns / 1ps

module swdk_debounce (
   input  logic clock,
   input  logic reset,
   input  logic sample_en,
   input  logic level,
   output logic release_det
);

   logic [swdk_pkg::DEBOUNCE_SAMPLES-1:0] hist_ff, hist_in;
   logic                                  deb_ff, deb_in;

   always_comb begin
      hist_in = {hist_ff[swdk_pkg::DEBOUNCE_SAMPLES-2:0], level};
      deb_in  = deb_ff;
      if (hist_in == '0) begin
         deb_in = 1'b0;
      end else if (hist_in == '1) begin
         deb_in = 1'b1;
      end
      release_det = deb_in & ~deb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '1;
         deb_ff  <= 1'b1;
      end else if (sample_en) begin
         hist_ff <= hist_in;
         deb_ff  <= deb_in;
      end
   end

endmodule

/* hw/rtl/swdk_counter.sv */
// swdk_counter: prescaler, hundredths and seconds counts (binary and BCD)
// and the run flag. Depends on swdk_pkg.
`timescale 1ns / 1ps

module swdk_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [7:0]                ticks_per_hundredth,
   input  logic                      stop_release,
   input  logic                      start_release,
   output swdk_pkg::count_view_type  view,
   output swdk_pkg::count_state_type next_state
);

   localparam int SD = swdk_pkg::SEC_BCD_DIGITS;

   logic [7:0]          prescale_ff, prescale_in;
   logic [6:0]          hund_ff, hund_in;
   logic [1:0][3:0]     hund_bcd_ff, hund_bcd_in;
   logic [13:0]         sec_ff, sec_in;
   logic [SD-1:0][3:0]  sec_bcd_ff, sec_bcd_in;
   logic                running_ff, running_in;
   logic                wrap;
   logic                carry;

   always_comb begin
      prescale_in = prescale_ff + 8'd1;
      hund_in     = hund_ff;
      hund_bcd_in = hund_bcd_ff;
      sec_in      = sec_ff;
      sec_bcd_in  = sec_bcd_ff;
      running_in  = running_ff;
      carry       = 1'b0;
      wrap = ({1'b0, prescale_ff} + 9'd1) >= {1'b0, ticks_per_hundredth};
      if (wrap) begin
         prescale_in = '0;
         if (running_ff) begin
            if (hund_ff >= 7'(swdk_pkg::HUND_LAST)) begin
               hund_in     = '0;
               hund_bcd_in = '0;
               if ({1'b0, sec_ff} + 15'd1 >= 15'(swdk_pkg::SECONDS_WRAP)) begin
                  sec_in     = '0;
                  sec_bcd_in = '0;
               end else begin
                  sec_in = sec_ff + 14'd1;
                  carry  = 1'b1;
                  for (int k = 0; k < SD; k++) begin
                     if (carry) begin
                        if (sec_bcd_ff[k] == 4'd9) begin
                           sec_bcd_in[k] = 4'd0;
                        end else begin
                           sec_bcd_in[k] = sec_bcd_ff[k] + 4'd1;
                           carry         = 1'b0;
                        end
                     end
                  end
               end
            end else begin
               hund_in = hund_ff + 7'd1;
               if (hund_bcd_ff[0] == 4'd9) begin
                  hund_bcd_in[0] = 4'd0;
                  hund_bcd_in[1] = hund_bcd_ff[1] + 4'd1;
               end else begin
                  hund_bcd_in[0] = hund_bcd_ff[0] + 4'd1;
               end
            end
         end
      end

      // display sees the stepped count, before the keys act
      view.hund_bcd = hund_bcd_in;
      view.sec_bcd  = sec_bcd_in;

      if (stop_release) begin
         hund_in     = '0;
         hund_bcd_in = '0;
         sec_in      = '0;
         sec_bcd_in  = '0;
         running_in  = 1'b0;
      end
      if (start_release) begin
         running_in = ~running_in;
      end

      next_state.running    = running_in;
      next_state.hundredths = hund_in;
      next_state.seconds    = sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         hund_ff     <= '0;
         hund_bcd_ff <= '0;
         sec_ff      <= '0;
         sec_bcd_ff  <= '0;
         running_ff  <= 1'b0;
      end else if (step_en) begin
         prescale_ff <= prescale_in;
         hund_ff     <= hund_in;
         hund_bcd_ff <= hund_bcd_in;
         sec_ff      <= sec_in;
         sec_bcd_ff  <= sec_bcd_in;
         running_ff  <= running_in;
      end
   end

   a_hund_bcd: assert property (@(posedge clock) disable iff (reset)
      hund_ff == 7'(hund_bcd_ff[1] * 4'd10 + 7'(hund_bcd_ff[0])))
      else $error("hundredths BCD out of step with binary count");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      (step_en && stop_release && !start_release) |=> (!running_ff && sec_ff == '0))
      else $error("stop release did not halt and clear");

endmodule

/* hw/rtl/swdk_display.sv */
// swdk_display: scan position and segment pattern for the digit being
// driven, with decimal point and leading-zero blanking. Depends on swdk_pkg.
`timescale 1ns / 1ps

module swdk_display (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  swdk_pkg::count_view_type view,
   output logic [2:0]               digit_select,
   output logic [7:0]               segment_pattern
);

   localparam int SD = swdk_pkg::SEC_BCD_DIGITS;

   logic [2:0] pos_ff, pos_in;
   logic [3:0] shown;
   logic       lit;

   always_comb begin
      pos_in = (pos_ff == 3'(swdk_pkg::DIGIT_COUNT - 1)) ? 3'd0 : pos_ff + 3'd1;
      shown  = '0;
      lit    = 1'b0;
      for (int k = 1; k <= swdk_pkg::DIGIT_COUNT - 3; k++) begin
         if (k < SD) begin
            if (int'(pos_ff) - 2 == k) begin
               shown = view.sec_bcd[k];
            end
            if (int'(pos_ff) - 2 <= k && view.sec_bcd[k] != 4'd0) begin
               lit = 1'b1;
            end
         end
      end
      case (pos_ff)
         3'd0: segment_pattern = swdk_pkg::seg_decode(view.hund_bcd[0]);
         3'd1: segment_pattern = swdk_pkg::seg_decode(view.hund_bcd[1]);
         3'd2: segment_pattern = swdk_pkg::seg_decode(view.sec_bcd[0]) & swdk_pkg::SEG_DP;
         default: segment_pattern = lit ? swdk_pkg::seg_decode(shown) : swdk_pkg::SEG_BLANK;
      endcase
      digit_select = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step_en) begin
         pos_ff <= pos_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < 3'(swdk_pkg::DIGIT_COUNT))
      else $error("scan position out of range");

endmodule

/* hw/rtl/stopwatch_with_debounced_keys.sv */
// Stopwatch with debounced keys: top level with the tick handshake, the
// rate register and the result register. Depends on swdk_pkg and submodules.
// A tick's result word is registered and valid the cycle after the tick is taken.
// Throughput: one tick per cycle; the result register stalls input only
// while a word is held and rsp_ready is low.
// Reset (synchronous): counts and scan clear, keys read released, rate 5.
`timescale 1ns / 1ps

module stopwatch_with_debounced_keys (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swdk_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output swdk_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_en,
   input  logic [7:0]             csr_write_data
);

   logic [7:0]                ticks_per_hundredth_ff;
   logic                      rsp_valid_ff;
   swdk_pkg::rsp_word_type    rsp_word_ff, rsp_word_in;
   logic                      accept;
   logic                      stop_release;
   logic                      start_release;
   swdk_pkg::count_view_type  view;
   swdk_pkg::count_state_type next_state;
   logic [2:0]                digit_select;
   logic [7:0]                segment_pattern;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   swdk_debounce u_stop_key (
      .clock       (clock),
      .reset       (reset),
      .sample_en   (accept),
      .level       (req_word.stop_key_level),
      .release_det (stop_release)
   );

   swdk_debounce u_start_key (
      .clock       (clock),
      .reset       (reset),
      .sample_en   (accept),
      .level       (req_word.start_key_level),
      .release_det (start_release)
   );

   swdk_counter u_counter (
      .clock               (clock),
      .reset               (reset),
      .step_en             (accept),
      .ticks_per_hundredth (ticks_per_hundredth_ff),
      .stop_release        (stop_release),
      .start_release       (start_release),
      .view                (view),
      .next_state          (next_state)
   );

   swdk_display u_display (
      .clock           (clock),
      .reset           (reset),
      .step_en         (accept),
      .view            (view),
      .digit_select    (digit_select),
      .segment_pattern (segment_pattern)
   );

   always_comb begin
      rsp_word_in.digit_select    = digit_select;
      rsp_word_in.segment_pattern = segment_pattern;
      rsp_word_in.is_running      = next_state.running;
      rsp_word_in.hundredths_now  = next_state.hundredths;
      rsp_word_in.seconds_now     = next_state.seconds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_hundredth_ff <= swdk_pkg::TPH_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (csr_write_en) begin
            ticks_per_hundredth_ff <= csr_write_data;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff && rsp_word_ff.seconds_now == $past(next_state.seconds)))
      else $error("accepted tick did not produce a result word");

endmodule
